>>> src/jts_pkg.sv
// Shared types and constants for the JSON token scanner.
// Token and queue record types, position width, queue depth.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jts_pkg;

	localparam int POSITION_BITS = 16;
	// offsets never exceed 16 bits, so the counters are capped at that width
	localparam int POS_W = (POSITION_BITS < 16) ? POSITION_BITS : 16;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [3:0] {
		CL_STRING = 4'd0,
		CL_INT    = 4'd1,
		CL_FLOAT  = 4'd2,
		CL_TRUE   = 4'd3,
		CL_FALSE  = 4'd4,
		CL_NULL   = 4'd5,
		CL_LBRACE = 4'd6,
		CL_RBRACE = 4'd7,
		CL_LBRACK = 4'd8,
		CL_RBRACK = 4'd9,
		CL_COMMA  = 4'd10,
		CL_COLON  = 4'd11,
		CL_SPACE  = 4'd12,
		CL_END    = 4'd13,
		CL_ERROR  = 4'd14
	} tok_class_t;

	typedef struct packed {
		tok_class_t  cls;
		logic [15:0] start;
		logic [15:0] len;
	} tok_t;

	// all tokens caused by one byte; t1 is used only when two is set
	typedef struct packed {
		logic two;
		tok_t t0;
		tok_t t1;
	} step_t;

	typedef struct packed {
		logic  push;
		step_t step;
	} q_wr_t;

	function automatic logic [15:0] ext16(input pos_t v);
		logic [15:0] r;
		r = '0;
		r[POS_W-1:0] = v;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> src/jts_front.sv
// Scanner front end: accepts bytes, runs the token automaton, builds the
// token records of each byte and pushes them into the queue.
// Depends on jts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jts_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire logic [7:0]     input_byte,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic           cfg_data,
	input  wire logic           q_full,
	output jts_pkg::q_wr_t      q_wr,
	output logic                halted
);
	import jts_pkg::*;

	typedef enum logic [5:0] {
		S_START   = 6'd0,
		S_STR     = 6'd2,
		S_COMMA   = 6'd3,
		S_MINUS   = 6'd4,
		S_ZERO    = 6'd5,
		S_INT     = 6'd6,
		S_COLON   = 6'd7,
		S_LBRK    = 6'd8,
		S_RBRK    = 6'd9,
		S_F       = 6'd10,
		S_N       = 6'd11,
		S_T       = 6'd12,
		S_LBRC    = 6'd13,
		S_RBRC    = 6'd14,
		S_WS      = 6'd15,
		S_STR_END = 6'd16,
		S_ESC     = 6'd17,
		S_FRAC    = 6'd18,
		S_EXP     = 6'd19,
		S_FA      = 6'd20,
		S_NU      = 6'd21,
		S_TR      = 6'd22,
		S_U0      = 6'd23,
		S_EXPS    = 6'd24,
		S_EXPD    = 6'd25,
		S_FAL     = 6'd26,
		S_NUL     = 6'd27,
		S_TRU     = 6'd28,
		S_U1      = 6'd29,
		S_FALS    = 6'd30,
		S_NULL    = 6'd31,
		S_TRUE    = 6'd32,
		S_U2      = 6'd33,
		S_FALSE   = 6'd34,
		S_U3      = 6'd35,
		S_HALT    = 6'd63
	} scan_t;

	typedef struct packed {
		logic  ok;
		scan_t st;
	} nxt_t;

	typedef struct packed {
		logic       acc;
		tok_class_t cls;
	} acc_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'd34;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'd46;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_EUP    = 8'd69;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_LBRK   = 8'h5b;
	localparam logic [7:0] CH_BSLASH = 8'd92;
	localparam logic [7:0] CH_RBRK   = 8'h5d;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LB     = 8'h62;
	localparam logic [7:0] CH_ELOW   = 8'd101;
	localparam logic [7:0] CH_LF_    = 8'h66;
	localparam logic [7:0] CH_LL     = 8'h6c;
	localparam logic [7:0] CH_LN     = 8'h6e;
	localparam logic [7:0] CH_LR     = 8'h72;
	localparam logic [7:0] CH_LS     = 8'h73;
	localparam logic [7:0] CH_LT     = 8'h74;
	localparam logic [7:0] CH_U      = 8'd117;
	localparam logic [7:0] CH_LBRC   = 8'h7b;
	localparam logic [7:0] CH_RBRC   = 8'h7d;

	localparam pos_t POS_MAX = '1;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || ((c >= CH_UA) && (c <= CH_UF)) ||
			((c >= CH_LA) && (c <= CH_LF_));
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_TAB) || (c == CH_LF) || (c == CH_SPACE);
	endfunction

	function automatic logic is_exp(input logic [7:0] c);
		return (c == CH_EUP) || (c == CH_ELOW);
	endfunction

	function automatic nxt_t next_state(input scan_t s, input logic [7:0] c);
		nxt_t r;
		r.ok = 1'b1;
		r.st = S_START;
		unique case (s)
			S_START: begin
				if (is_ws(c))                              r.st = S_WS;
				else if (c == CH_QUOTE)                    r.st = S_STR;
				else if (c == CH_COMMA)                    r.st = S_COMMA;
				else if (c == CH_MINUS)                    r.st = S_MINUS;
				else if (c == CH_ZERO)                     r.st = S_ZERO;
				else if (c >= CH_ONE && c <= CH_NINE)      r.st = S_INT;
				else if (c == CH_COLON)                    r.st = S_COLON;
				else if (c == CH_LBRK)                     r.st = S_LBRK;
				else if (c == CH_RBRK)                     r.st = S_RBRK;
				else if (c == CH_LF_)                      r.st = S_F;
				else if (c == CH_LN)                       r.st = S_N;
				else if (c == CH_LT)                       r.st = S_T;
				else if (c == CH_LBRC)                     r.st = S_LBRC;
				else if (c == CH_RBRC)                     r.st = S_RBRC;
				else                                       r.ok = 1'b0;
			end
			S_STR: begin
				if (c == CH_QUOTE)       r.st = S_STR_END;
				else if (c == CH_BSLASH) r.st = S_ESC;
				else                     r.st = S_STR;
			end
			S_MINUS: begin
				if (c == CH_ZERO)                     r.st = S_ZERO;
				else if (c >= CH_ONE && c <= CH_NINE) r.st = S_INT;
				else                                  r.ok = 1'b0;
			end
			S_ZERO: begin
				if (c == CH_DOT)    r.st = S_FRAC;
				else if (is_exp(c)) r.st = S_EXP;
				else                r.ok = 1'b0;
			end
			S_INT: begin
				if (c == CH_DOT)      r.st = S_FRAC;
				else if (is_digit(c)) r.st = S_INT;
				else if (is_exp(c))   r.st = S_EXP;
				else                  r.ok = 1'b0;
			end
			S_F: begin r.st = S_FA; r.ok = (c == CH_LA); end
			S_N: begin r.st = S_NU; r.ok = (c == CH_U); end
			S_T: begin r.st = S_TR; r.ok = (c == CH_LR); end
			S_WS: begin r.st = S_WS; r.ok = is_ws(c); end
			S_ESC: begin
				if (c == CH_QUOTE || c == CH_SLASH || c == CH_BSLASH || c == CH_LB ||
					c == CH_LF_ || c == CH_LN || c == CH_LR || c == CH_LT) begin
					r.st = S_STR;
				end else if (c == CH_U) begin
					r.st = S_U0;
				end else begin
					r.ok = 1'b0;
				end
			end
			S_FRAC: begin
				if (is_digit(c))    r.st = S_FRAC;
				else if (is_exp(c)) r.st = S_EXP;
				else                r.ok = 1'b0;
			end
			S_EXP: begin
				if (c == CH_PLUS || c == CH_MINUS) r.st = S_EXPS;
				else if (is_digit(c))              r.st = S_EXPD;
				else                               r.ok = 1'b0;
			end
			S_FA:   begin r.st = S_FAL;   r.ok = (c == CH_LL); end
			S_NU:   begin r.st = S_NUL;   r.ok = (c == CH_LL); end
			S_TR:   begin r.st = S_TRU;   r.ok = (c == CH_U); end
			S_U0:   begin r.st = S_U1;    r.ok = is_hex(c); end
			S_EXPS: begin r.st = S_EXPD;  r.ok = is_digit(c); end
			S_EXPD: begin r.st = S_EXPD;  r.ok = is_digit(c); end
			S_FAL:  begin r.st = S_FALS;  r.ok = (c == CH_LS); end
			S_NUL:  begin r.st = S_NULL;  r.ok = (c == CH_LL); end
			S_TRU:  begin r.st = S_TRUE;  r.ok = (c == CH_ELOW); end
			S_U1:   begin r.st = S_U2;    r.ok = is_hex(c); end
			S_FALS: begin r.st = S_FALSE; r.ok = (c == CH_ELOW); end
			S_U2:   begin r.st = S_U3;    r.ok = is_hex(c); end
			S_U3:   begin r.st = S_STR;   r.ok = is_hex(c); end
			default: r.ok = 1'b0;
		endcase
		return r;
	endfunction

	function automatic acc_t class_of(input scan_t s);
		acc_t r;
		r.acc = 1'b1;
		r.cls = CL_ERROR;
		unique case (s)
			S_COMMA:            r.cls = CL_COMMA;
			S_ZERO, S_INT:      r.cls = CL_INT;
			S_COLON:            r.cls = CL_COLON;
			S_LBRK:             r.cls = CL_LBRACK;
			S_RBRK:             r.cls = CL_RBRACK;
			S_LBRC:             r.cls = CL_LBRACE;
			S_RBRC:             r.cls = CL_RBRACE;
			S_WS:               r.cls = CL_SPACE;
			S_STR_END:          r.cls = CL_STRING;
			S_FRAC, S_EXPD:     r.cls = CL_FLOAT;
			S_NULL:             r.cls = CL_NULL;
			S_TRUE:             r.cls = CL_TRUE;
			S_FALSE:            r.cls = CL_FALSE;
			default:            r.acc = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic closes(input scan_t s);
		return s inside {S_COMMA, S_COLON, S_LBRK, S_RBRK, S_LBRC, S_RBRC,
			S_STR_END, S_NULL, S_TRUE, S_FALSE};
	endfunction

	scan_t state_q, state_n;
	pos_t  pos_q, pos_n, beg_q, beg_n, after;
	logic  skip_q;
	logic  accept;
	logic  ta_v, tb_v, a_keep, b_keep, rescan;
	tok_t  ta, tb;
	nxt_t  nx, nx0;
	acc_t  ac, ac0, acn;

	assign in_stall  = q_full;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign halted    = (state_q == S_HALT);
	assign after     = (pos_q == POS_MAX) ? POS_MAX : pos_q + pos_t'(1);

	always_comb begin
		nx      = next_state(state_q, input_byte);
		ac      = class_of(state_q);
		nx0     = next_state(S_START, input_byte);
		ac0     = class_of(nx0.st);
		acn     = class_of(nx.st);
		ta_v    = 1'b0;
		tb_v    = 1'b0;
		ta      = '{cls: CL_ERROR, start: ext16(beg_q), len: ext16(pos_t'(pos_q - beg_q))};
		tb      = '{cls: CL_END, start: ext16(pos_q), len: '0};
		rescan  = 1'b0;
		state_n = state_q;
		pos_n   = after;
		beg_n   = beg_q;
		if (input_byte == CH_NUL) begin
			// end of input: flush the pending token and restart at offset zero
			if (state_q == S_START) begin
				tb_v = 1'b1;
			end else if (state_q != S_HALT) begin
				ta_v = 1'b1;
				if (ac.acc) begin
					ta.cls = ac.cls;
					tb_v   = 1'b1;
				end
			end
			state_n = S_START;
			pos_n   = '0;
			beg_n   = '0;
		end else if (state_q == S_HALT) begin
			pos_n = pos_q;
		end else begin
			if (state_q == S_START) begin
				rescan = 1'b1;
			end else if (nx.ok) begin
				if (closes(nx.st)) begin
					ta_v    = 1'b1;
					ta.cls  = acn.cls;
					ta.len  = ext16(pos_t'(after - beg_q));
					state_n = S_START;
				end else begin
					state_n = nx.st;
				end
			end else if (!ac.acc) begin
				ta_v    = 1'b1;
				ta.len  = ext16(pos_t'(after - beg_q));
				state_n = S_HALT;
			end else begin
				ta_v   = 1'b1;
				ta.cls = ac.cls;
				rescan = 1'b1;
			end
			if (rescan) begin
				beg_n    = pos_q;
				tb.start = ext16(pos_q);
				tb.len   = ext16(pos_t'(after - pos_q));
				if (!nx0.ok) begin
					tb_v    = 1'b1;
					tb.cls  = CL_ERROR;
					state_n = S_HALT;
				end else if (closes(nx0.st)) begin
					tb_v    = 1'b1;
					tb.cls  = ac0.cls;
					state_n = S_START;
				end else begin
					state_n = nx0.st;
				end
			end
		end
	end

	// drop whitespace tokens when configured, then pack into the record
	assign a_keep = ta_v && !(ta.cls == CL_SPACE && skip_q);
	assign b_keep = tb_v && !(tb.cls == CL_SPACE && skip_q);

	always_comb begin
		q_wr.push    = accept && (a_keep || b_keep);
		q_wr.step.two = a_keep && b_keep;
		q_wr.step.t0 = a_keep ? ta : tb;
		q_wr.step.t1 = tb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_START;
			pos_q   <= '0;
			beg_q   <= '0;
			skip_q  <= 1'b1;
		end else begin
			if (accept) begin
				state_q <= state_n;
				pos_q   <= pos_n;
				beg_q   <= beg_n;
			end
			if (cfg_valid && cfg_ready) begin
				skip_q <= cfg_data;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/jts_queue.sv
// Short queue of per-byte token records between scanner front and back end.
// Register array with read and write pointers. Depends on jts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jts_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire jts_pkg::q_wr_t  wr,
	output logic                 full,
	output logic                 head_valid,
	output jts_pkg::step_t       head,
	input  wire logic            pop
);
	import jts_pkg::*;

	step_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = wr.push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr.step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
		end
	end

endmodule

`default_nettype wire

>>> src/jts_back.sv
// Scanner back end: pops token records and delivers their tokens one per
// transaction through the output register. Depends on jts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jts_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire jts_pkg::step_t  head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [3:0]           token_class,
	output logic [15:0]          token_start,
	output logic [15:0]          token_length,
	output logic                 last_of_run,
	output logic                 pending
);
	import jts_pkg::*;

	logic out_valid_q, pend_q, last_q, out_free;
	tok_t out_tok_q, pend_tok_q;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = out_free && !pend_q && head_valid;

	assign out_valid    = out_valid_q;
	assign token_class  = out_tok_q.cls;
	assign token_start  = out_tok_q.start;
	assign token_length = out_tok_q.len;
	assign last_of_run  = last_q;
	assign pending      = pend_q;

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				out_tok_q <= pend_tok_q;
				last_q    <= 1'b1;
			end else begin
				out_tok_q  <= head.t0;
				last_q     <= !head.two;
				pend_tok_q <= head.t1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				// hold the second token of a two-token byte for the next transaction
				out_valid_q <= head_valid;
				pend_q      <= head_valid && head.two;
			end
		end
	end

endmodule

`default_nettype wire

>>> src/json_token_scanner_top.sv
// JSON token scanner: one byte per cycle while in_stall is low.
// Path: a byte's token record passes through the record queue, then the output register.
// Throughput: one byte per cycle while the 4-entry record queue has room;
// the output delivers one token per cycle while out_stall is low, and a two-token byte gives two tokens.
// Reset: automaton at start state, offsets zero, queue empty, skip_whitespace 1.
// Depends on jts_pkg, jts_front, jts_queue, jts_back.
`timescale 1ns / 1ps
`default_nettype none

module json_token_scanner_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  input_byte,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [3:0]       token_class,
	output logic [15:0]      token_start,
	output logic [15:0]      token_length,
	output logic             last_of_run
);
	import jts_pkg::*;

	q_wr_t q_wr;
	step_t head;
	logic  q_full, head_valid, pop, halted, pending;

	jts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.input_byte (input_byte),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.q_wr       (q_wr),
		.halted     (halted)
	);

	jts_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (q_wr),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	jts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_class  (token_class),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run),
		.pending      (pending)
	);

	// a held second token always sits behind a visible first one
	a_pend_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pending |-> out_valid)
		else $error("second token pending without a valid output");

	a_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last_of_run) |-> pending)
		else $error("non-final token without a pending successor");

	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(halted && in_valid && !in_stall && input_byte != 8'h00) |-> !q_wr.push)
		else $error("halted scanner produced a token");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head_valid && !pending))
		else $error("queue popped while empty or with a token pending");

endmodule

`default_nettype wire

>>> tb/tb_json_token_scanner_top.sv
// Self-checking bench for json_token_scanner_top: a directed byte table and random
// token streams, checked against a byte-level lexer or against fixed table rows.
// Depends on jts_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb_json_token_scanner_top;
	import jts_pkg::*;

	localparam int RANDOM_ITEMS = 1720;
	localparam int RANDOM_PHASES = 6;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int unsigned POS_MAX = (32'd1 << POS_W) - 1;

	// lexer states
	localparam logic [5:0] ST_START    = 6'd0;
	localparam logic [5:0] ST_STR      = 6'd2;
	localparam logic [5:0] ST_COMMA    = 6'd3;
	localparam logic [5:0] ST_MINUS    = 6'd4;
	localparam logic [5:0] ST_ZERO     = 6'd5;
	localparam logic [5:0] ST_DIGITS   = 6'd6;
	localparam logic [5:0] ST_COLON    = 6'd7;
	localparam logic [5:0] ST_LBRACK   = 6'd8;
	localparam logic [5:0] ST_RBRACK   = 6'd9;
	localparam logic [5:0] ST_F        = 6'd10;
	localparam logic [5:0] ST_N        = 6'd11;
	localparam logic [5:0] ST_T        = 6'd12;
	localparam logic [5:0] ST_LBRACE   = 6'd13;
	localparam logic [5:0] ST_RBRACE   = 6'd14;
	localparam logic [5:0] ST_WS       = 6'd15;
	localparam logic [5:0] ST_STR_END  = 6'd16;
	localparam logic [5:0] ST_ESC      = 6'd17;
	localparam logic [5:0] ST_FRAC     = 6'd18;
	localparam logic [5:0] ST_EXP      = 6'd19;
	localparam logic [5:0] ST_FA       = 6'd20;
	localparam logic [5:0] ST_NU       = 6'd21;
	localparam logic [5:0] ST_TR       = 6'd22;
	localparam logic [5:0] ST_U0       = 6'd23;
	localparam logic [5:0] ST_EXP_SIGN = 6'd24;
	localparam logic [5:0] ST_EXP_DIG  = 6'd25;
	localparam logic [5:0] ST_FAL      = 6'd26;
	localparam logic [5:0] ST_NUL      = 6'd27;
	localparam logic [5:0] ST_TRU      = 6'd28;
	localparam logic [5:0] ST_U1       = 6'd29;
	localparam logic [5:0] ST_FALS     = 6'd30;
	localparam logic [5:0] ST_NULL     = 6'd31;
	localparam logic [5:0] ST_TRUE     = 6'd32;
	localparam logic [5:0] ST_U2       = 6'd33;
	localparam logic [5:0] ST_FALSE    = 6'd34;
	localparam logic [5:0] ST_U3       = 6'd35;
	localparam logic [5:0] ST_NONE     = 6'd62;
	localparam logic [5:0] ST_HALT     = 6'd63;

	typedef struct packed {
		tok_class_t  cls;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} tok_rec_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        known;
		tok_class_t  cls;
		logic [15:0] start;
		logic [15:0] len;
	} byte_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  input_byte = 8'h00;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  token_class;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	tok_rec_t    tokens_due[$];
	tok_rec_t    fresh_toks[$];
	logic [7:0]  src_bytes[$];
	byte_row_t   byte_table[$];

	logic [5:0]  lx_state = ST_START;
	int unsigned lx_pos = 0;
	int unsigned lx_begin = 0;
	bit          lx_skip = 1'b1;

	bit          calm = 1'b0;
	int          stall_left = 0;
	int          idle_cycles = 0;
	int          mismatches = 0;
	int          tokens_seen = 0;

	json_token_scanner_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.input_byte   (input_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.token_class  (token_class),
		.token_start  (token_start),
		.token_length (token_length),
		.last_of_run  (last_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [5:0] next_scan(input logic [5:0] s, input logic [7:0] c);
		bit dig;
		bit hex;
		bit ex;
		dig = (c >= "0") && (c <= "9");
		hex = dig || ((c >= "A") && (c <= "F")) || ((c >= "a") && (c <= "f"));
		ex = (c == "e") || (c == "E");
		next_scan = ST_NONE;
		case (s)
			ST_START: begin
				case (c)
					"\t", "\n", " ": next_scan = ST_WS;
					"\"": next_scan = ST_STR;
					",": next_scan = ST_COMMA;
					"-": next_scan = ST_MINUS;
					"0": next_scan = ST_ZERO;
					":": next_scan = ST_COLON;
					"[": next_scan = ST_LBRACK;
					"]": next_scan = ST_RBRACK;
					"f": next_scan = ST_F;
					"n": next_scan = ST_N;
					"t": next_scan = ST_T;
					"{": next_scan = ST_LBRACE;
					"}": next_scan = ST_RBRACE;
					default: if (dig) next_scan = ST_DIGITS;
				endcase
			end
			ST_STR: begin
				if (c == "\"") next_scan = ST_STR_END;
				else if (c == "\\") next_scan = ST_ESC;
				else next_scan = ST_STR;
			end
			ST_MINUS: begin
				if (c == "0") next_scan = ST_ZERO;
				else if (dig) next_scan = ST_DIGITS;
			end
			ST_ZERO: begin
				if (c == ".") next_scan = ST_FRAC;
				else if (ex) next_scan = ST_EXP;
			end
			ST_DIGITS: begin
				if (c == ".") next_scan = ST_FRAC;
				else if (dig) next_scan = ST_DIGITS;
				else if (ex) next_scan = ST_EXP;
			end
			ST_F: if (c == "a") next_scan = ST_FA;
			ST_N: if (c == "u") next_scan = ST_NU;
			ST_T: if (c == "r") next_scan = ST_TR;
			ST_WS: if (c == "\t" || c == "\n" || c == " ") next_scan = ST_WS;
			ST_ESC: begin
				case (c)
					"\"", "/", "\\", "b", "f", "n", "r", "t": next_scan = ST_STR;
					"u": next_scan = ST_U0;
					default: next_scan = ST_NONE;
				endcase
			end
			ST_FRAC: begin
				if (dig) next_scan = ST_FRAC;
				else if (ex) next_scan = ST_EXP;
			end
			ST_EXP: begin
				if (c == "+" || c == "-") next_scan = ST_EXP_SIGN;
				else if (dig) next_scan = ST_EXP_DIG;
			end
			ST_EXP_SIGN, ST_EXP_DIG: if (dig) next_scan = ST_EXP_DIG;
			ST_FA: if (c == "l") next_scan = ST_FAL;
			ST_NU: if (c == "l") next_scan = ST_NUL;
			ST_TR: if (c == "u") next_scan = ST_TRU;
			ST_FAL: if (c == "s") next_scan = ST_FALS;
			ST_NUL: if (c == "l") next_scan = ST_NULL;
			ST_TRU: if (c == "e") next_scan = ST_TRUE;
			ST_FALS: if (c == "e") next_scan = ST_FALSE;
			ST_U0: if (hex) next_scan = ST_U1;
			ST_U1: if (hex) next_scan = ST_U2;
			ST_U2: if (hex) next_scan = ST_U3;
			ST_U3: if (hex) next_scan = ST_STR;
			default: next_scan = ST_NONE;
		endcase
	endfunction

	// CL_ERROR here means the state accepts nothing
	function automatic tok_class_t class_of(input logic [5:0] s);
		case (s)
			ST_COMMA: class_of = CL_COMMA;
			ST_ZERO, ST_DIGITS: class_of = CL_INT;
			ST_COLON: class_of = CL_COLON;
			ST_LBRACK: class_of = CL_LBRACK;
			ST_RBRACK: class_of = CL_RBRACK;
			ST_LBRACE: class_of = CL_LBRACE;
			ST_RBRACE: class_of = CL_RBRACE;
			ST_WS: class_of = CL_SPACE;
			ST_STR_END: class_of = CL_STRING;
			ST_FRAC, ST_EXP_DIG: class_of = CL_FLOAT;
			ST_NULL: class_of = CL_NULL;
			ST_TRUE: class_of = CL_TRUE;
			ST_FALSE: class_of = CL_FALSE;
			default: class_of = CL_ERROR;
		endcase
	endfunction

	function automatic bit closes_now(input logic [5:0] s);
		case (s)
			ST_COMMA, ST_COLON, ST_LBRACK, ST_RBRACK, ST_LBRACE, ST_RBRACE,
			ST_STR_END, ST_NULL, ST_TRUE, ST_FALSE: closes_now = 1'b1;
			default: closes_now = 1'b0;
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(13, 40);
	endfunction

	function automatic byte_row_t row_scan(input logic [7:0] b);
		byte_row_t r;
		r = '0;
		r.b = b;
		r.cls = CL_ERROR;
		return r;
	endfunction

	function automatic byte_row_t row_known(input logic [7:0] b, input tok_class_t cls,
			input logic [15:0] start, input logic [15:0] len);
		byte_row_t r;
		r.b = b;
		r.known = 1'b1;
		r.cls = cls;
		r.start = start;
		r.len = len;
		return r;
	endfunction

	task automatic put_tok(input tok_class_t cls, input int unsigned start,
			input int unsigned len);
		tok_rec_t r;
		if (cls == CL_SPACE && lx_skip)
			return;
		r.cls = cls;
		r.start = start[15:0];
		r.len = len[15:0];
		r.last = 1'b0;
		fresh_toks.push_back(r);
	endtask

	// Advance the lexer by one byte; leaves the tokens it causes in fresh_toks.
	task automatic lex_byte(input logic [7:0] c);
		logic [5:0]  s;
		logic [5:0]  t;
		int unsigned pos;
		int unsigned after;
		bit          rescan;
		tok_rec_t    r;
		fresh_toks.delete();
		s = lx_state;
		pos = lx_pos;
		after = (pos >= POS_MAX) ? POS_MAX : pos + 1;
		if (c == 8'h00) begin
			if (s == ST_START) begin
				put_tok(CL_END, pos, 0);
			end else if (s != ST_HALT && class_of(s) != CL_ERROR) begin
				put_tok(class_of(s), lx_begin, pos - lx_begin);
				put_tok(CL_END, pos, 0);
			end else if (s != ST_HALT) begin
				put_tok(CL_ERROR, lx_begin, pos - lx_begin);
			end
			lx_state = ST_START;
			lx_pos = 0;
			lx_begin = 0;
		end else if (s != ST_HALT) begin
			rescan = 1'b1;
			if (s != ST_START) begin
				t = next_scan(s, c);
				if (t != ST_NONE) begin
					rescan = 1'b0;
					if (closes_now(t)) begin
						put_tok(class_of(t), lx_begin, after - lx_begin);
						s = ST_START;
					end else begin
						s = t;
					end
				end else if (class_of(s) == CL_ERROR) begin
					rescan = 1'b0;
					put_tok(CL_ERROR, lx_begin, after - lx_begin);
					s = ST_HALT;
				end else begin
					put_tok(class_of(s), lx_begin, pos - lx_begin);
					s = ST_START;
				end
			end
			if (rescan) begin
				t = next_scan(ST_START, c);
				lx_begin = pos;
				if (t == ST_NONE) begin
					put_tok(CL_ERROR, pos, after - pos);
					s = ST_HALT;
				end else if (closes_now(t)) begin
					put_tok(class_of(t), pos, after - pos);
					s = ST_START;
				end else begin
					s = t;
				end
			end
			lx_state = s;
			lx_pos = after;
		end
		if (fresh_toks.size() > 0) begin
			r = fresh_toks.pop_back();
			r.last = 1'b1;
			fresh_toks.push_back(r);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = calm ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		input_byte <= b;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	task automatic feed_byte(input logic [7:0] b);
		send_byte(b);
		lex_byte(b);
		foreach (fresh_toks[i]) tokens_due.push_back(fresh_toks[i]);
	endtask

	// Hold input idle until every token due has come out, then let the pipe empty.
	task automatic settle();
		in_valid <= 1'b0;
		while (tokens_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_skip(input bit v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		lx_skip = v;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) src_bytes.push_back(s[i]);
	endtask

	// Append one random lexeme (mostly well formed) to src_bytes.
	task automatic make_lexeme();
		int    k;
		int    r;
		string esc;
		string hexs;
		string punc;
		esc = "\"/\\bfnrt";
		hexs = "0123456789abcdefABCDEF";
		punc = "{}[],:";
		k = $urandom_range(0, 99);
		if (k < 18) begin
			src_bytes.push_back("\"");
			repeat ($urandom_range(0, 6)) begin
				r = $urandom_range(0, 99);
				if (r < 10) begin
					src_bytes.push_back("\\");
					src_bytes.push_back(esc[$urandom_range(0, esc.len() - 1)]);
				end else if (r < 18) begin
					push_text("\\u");
					repeat (4) src_bytes.push_back(hexs[$urandom_range(0, hexs.len() - 1)]);
				end else if (r < 33) begin
					src_bytes.push_back(8'($urandom_range(128, 255)));
				end else if (r < 38) begin
					src_bytes.push_back(8'($urandom_range(1, 31)));
				end else begin
					r = $urandom_range(32, 126);
					src_bytes.push_back((r == 34 || r == 92) ? "x" : 8'(r));
				end
			end
			// leave a few open so later bytes run into the string
			if ($urandom_range(0, 9) != 0) src_bytes.push_back("\"");
		end else if (k < 36) begin
			if ($urandom_range(0, 3) == 0) src_bytes.push_back("-");
			if ($urandom_range(0, 3) == 0) begin
				src_bytes.push_back("0");
			end else begin
				src_bytes.push_back(8'($urandom_range(49, 57)));
				repeat ($urandom_range(0, 3)) src_bytes.push_back(8'($urandom_range(48, 57)));
			end
			if ($urandom_range(0, 1) == 1) begin
				src_bytes.push_back(".");
				repeat ($urandom_range(1, 3)) src_bytes.push_back(8'($urandom_range(48, 57)));
			end
			if ($urandom_range(0, 2) == 0) begin
				src_bytes.push_back($urandom_range(0, 1) ? "e" : "E");
				r = $urandom_range(0, 2);
				if (r == 1) src_bytes.push_back("+");
				if (r == 2) src_bytes.push_back("-");
				repeat ($urandom_range(1, 2)) src_bytes.push_back(8'($urandom_range(48, 57)));
			end
		end else if (k < 46) begin
			case ($urandom_range(0, 2))
				0: push_text("true");
				1: push_text("false");
				default: push_text("null");
			endcase
		end else if (k < 68) begin
			src_bytes.push_back(punc[$urandom_range(0, punc.len() - 1)]);
		end else if (k < 78) begin
			repeat ($urandom_range(1, 3)) begin
				r = $urandom_range(0, 2);
				src_bytes.push_back(r == 0 ? "\t" : (r == 1 ? "\n" : " "));
			end
		end else if (k < 84) begin
			src_bytes.push_back(8'h00);
		end else if (k < 92) begin
			case ($urandom_range(0, 9))
				0: push_text("tr");
				1: push_text("fals");
				2: push_text("nu");
				3: push_text("-");
				4: push_text("1e");
				5: push_text("2.");
				6: push_text("1e+");
				7: push_text("\"\\");
				8: push_text("\"\\u1f");
				default: push_text("\"ab");
			endcase
		end else begin
			src_bytes.push_back(8'($urandom_range(1, 255)));
		end
	endtask

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin : drive_out_stall
		int n;
		if (calm) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			n = gap_len();
			out_stall <= (n > 0);
			stall_left <= (n > 0) ? n - 1 : 0;
		end
	end

	always @(posedge clk) begin : check_tokens
		tok_rec_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (tokens_due.size() == 0) begin
				report_mismatch($sformatf("unexpected token class %0d start %0d length %0d",
					token_class, token_start, token_length));
			end else begin
				want = tokens_due.pop_front();
				if (token_class !== want.cls)
					report_mismatch($sformatf("token %0d class: got %0d want %0d",
						tokens_seen, token_class, want.cls));
				if (token_start !== want.start)
					report_mismatch($sformatf("token %0d start: got %0d want %0d",
						tokens_seen, token_start, want.start));
				if (token_length !== want.len)
					report_mismatch($sformatf("token %0d length: got %0d want %0d",
						tokens_seen, token_length, want.len));
				if (last_of_run !== want.last)
					report_mismatch($sformatf("token %0d last_of_run: got %0b want %0b",
						tokens_seen, last_of_run, want.last));
			end
			tokens_seen++;
		end
	end

	// Count cycles in which no transaction moves on any channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		byte_row_t  row;
		logic [7:0] b;
		int         fed;
		int         goal;

		// punctuation, a literal, a float closed by punctuation, bad escape,
		// halted bytes, unknown start bytes, end inside a partial word
		byte_table.push_back(row_known(8'h00, CL_END, 16'd0, 16'd0));
		byte_table.push_back(row_known("[", CL_LBRACK, 16'd0, 16'd1));
		byte_table.push_back(row_scan("t"));
		byte_table.push_back(row_scan("r"));
		byte_table.push_back(row_scan("u"));
		byte_table.push_back(row_scan("e"));
		byte_table.push_back(row_scan(","));
		byte_table.push_back(row_scan("-"));
		byte_table.push_back(row_scan("0"));
		byte_table.push_back(row_scan("."));
		byte_table.push_back(row_scan("5"));
		byte_table.push_back(row_scan("e"));
		byte_table.push_back(row_scan("-"));
		byte_table.push_back(row_scan("9"));
		byte_table.push_back(row_scan("]"));
		byte_table.push_back(row_scan(8'h00));
		byte_table.push_back(row_scan("\""));
		byte_table.push_back(row_scan("\\"));
		byte_table.push_back(row_known("q", CL_ERROR, 16'd0, 16'd3));
		byte_table.push_back(row_scan("x"));
		byte_table.push_back(row_scan(8'h00));
		byte_table.push_back(row_known("@", CL_ERROR, 16'd0, 16'd1));
		byte_table.push_back(row_scan(8'h00));
		byte_table.push_back(row_scan("7"));
		byte_table.push_back(row_scan(8'h00));
		byte_table.push_back(row_scan("n"));
		byte_table.push_back(row_scan("u"));
		byte_table.push_back(row_known(8'h00, CL_ERROR, 16'd0, 16'd2));
		byte_table.push_back(row_known(8'hFF, CL_ERROR, 16'd0, 16'd1));
		byte_table.push_back(row_scan(8'h00));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (byte_table[i]) begin
			row = byte_table[i];
			send_byte(row.b);
			lex_byte(row.b);
			if (row.known) begin
				tokens_due.push_back({row.cls, row.start, row.len, 1'b1});
			end else begin
				foreach (fresh_toks[j]) tokens_due.push_back(fresh_toks[j]);
			end
		end

		// random token streams
		fed = 0;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			write_skip(phase < 2 ? phase[0] : 1'($urandom_range(0, 1)));
			calm = (phase == 2) || ($urandom_range(0, 3) == 0);
			goal = RANDOM_ITEMS * (phase + 1) / RANDOM_PHASES;
			while (fed < goal) begin
				make_lexeme();
				while (src_bytes.size() > 0) begin
					b = src_bytes.pop_front();
					fed++;
					feed_byte(b);
				end
			end
		end
		calm = 1'b0;

		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> files.f
src/jts_pkg.sv
src/jts_front.sv
src/jts_queue.sv
src/jts_back.sv
src/json_token_scanner_top.sv
tb/tb_json_token_scanner_top.sv
